FILE: rtl/tfcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcrc_pkg
// Shared types, constants and the byte-wise CRC-16/X-25 update used by the
// tracker frame check.
// ----------------------------------------------------------------------------
package tfcrc_pkg;

    // Frame layout constants.
    localparam logic [7:0]  LONG_MARK      = 8'h79;
    localparam logic [15:0] LONG_OVERHEAD  = 16'd6;
    localparam logic [15:0] SHORT_OVERHEAD = 16'd5;
    localparam logic [15:0] SHORT_CAP      = 16'd250;

    // CRC-16/X-25: reflected polynomial, all-ones init, inverted at the end.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    localparam int COUNT_W = 11;

    // Position within the frame layout.
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START2  = 4'd1,
        PH_LEN_HI  = 4'd2,
        PH_LEN_LO  = 4'd3,
        PH_PROTO   = 4'd4,
        PH_INFO    = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_SER1    = 4'd7,
        PH_SER2    = 4'd8
    } t_phase;

    // One finished frame check, handed from the frame tracker to the top.
    typedef struct packed {
        logic               valid;
        logic [15:0]        crc_value;
        logic               long_frame;
        logic [COUNT_W-1:0] covered_count;
    } t_result;

    // Fold one byte into a reflected CRC, least significant bit first.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/tracker_frame_crc_itu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_frame_crc_itu_top
// CRC-16/X-25 frame check over tracker frames, one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one frame byte per
//   request with i_frame_start set on the first start byte. Output channel
//   (o_out_valid / i_out_ready) carries one result per complete frame: the
//   finished CRC, the long-frame flag and the covered payload count.
//   A byte is registered on acceptance and processed by the frame tracker
//   once the output register can take a result; the output register then
//   takes the result of the second serial byte. Throughput is one byte per
//   cycle while the output is not stalled, with a byte-wise CRC update.
//   When the receiver stalls, the result stays in the output register and the
//   input register takes at most one more byte; after that o_in_ready drops
//   until the result is taken.
//   Reset (synchronous, active low) empties both registers and returns the
//   tracker to idle; bytes without a start mark are ignored while idle.
// ----------------------------------------------------------------------------
module tracker_frame_crc_itu_top
    import tfcrc_pkg::*;
#(
    parameter int DATA_CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_wire_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_crc_value,
    output logic        o_long_frame,
    output logic [10:0] o_covered_count
);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_start;
    logic        w_adv;
    t_result     w_res;
    logic        r_out_valid;
    logic [15:0] r_crc_value;
    logic        r_long_frame;
    logic [10:0] r_covered;

    // The tracker stage advances whenever the output register can take a result.
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte  <= i_wire_byte;
            r_start <= i_frame_start;
        end
    end

    // Frame tracker and CRC.
    tfcrc_core #(
        .DATA_CAPACITY (DATA_CAPACITY)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_in_valid && w_adv),
        .i_byte   (r_byte),
        .i_start  (r_start),
        .o_result (w_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid && w_res.valid) begin
            r_crc_value  <= w_res.crc_value;
            r_long_frame <= w_res.long_frame;
            r_covered    <= w_res.covered_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_crc_value     = r_crc_value;
    assign o_long_frame    = r_long_frame;
    assign o_covered_count = r_covered;

    // A result leaving the tracker must show up in the output register.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_adv && w_res.valid |=> o_out_valid)
        else $error("tracker result was not captured");

    // The input side may only be blocked while a result is held back.
    a_block_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input blocked without an output stall");

    // Short frames never cover more than the short-frame limit.
    a_short_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_long_frame |-> ({5'd0, o_covered_count} <= SHORT_CAP))
        else $error("short frame covered count above limit");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

FILE: rtl/tfcrc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcrc_core
// Frame tracker: follows the frame layout one byte per enable and keeps the
// running CRC, the declared length and the payload counter.
// ----------------------------------------------------------------------------
module tfcrc_core
    import tfcrc_pkg::*;
#(
    parameter int DATA_CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    output t_result     o_result
);

    localparam logic [15:0] CAP = 16'(DATA_CAPACITY);

    t_phase      r_phase,   n_phase;
    logic        r_is_long, n_is_long;
    logic [15:0] r_len,     n_len;
    logic [15:0] r_cnt,     n_cnt;
    logic [15:0] r_crc,     n_crc;
    logic [15:0] r_ptotal,  n_ptotal;
    logic [15:0] r_cov,     n_cov;

    logic [15:0] w_fold;
    logic [15:0] w_sub;
    logic [15:0] w_ptotal;
    logic [15:0] w_cov;

    // Payload and covered counts from the declared length.
    always_comb begin
        w_sub    = r_is_long ? LONG_OVERHEAD : SHORT_OVERHEAD;
        w_ptotal = (r_len > w_sub) ? (r_len - w_sub) : 16'd0;
        w_cov    = (w_ptotal > CAP) ? CAP : w_ptotal;
        if (!r_is_long && (w_cov > SHORT_CAP)) begin
            w_cov = SHORT_CAP;
        end
    end

    assign w_fold = crc_fold(r_crc, i_byte);

    // Next state for one byte.
    always_comb begin
        n_phase   = r_phase;
        n_is_long = r_is_long;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_crc     = r_crc;
        n_ptotal  = r_ptotal;
        n_cov     = r_cov;

        o_result.valid         = 1'b0;
        o_result.crc_value     = ~w_fold;
        o_result.long_frame    = r_is_long;
        o_result.covered_count = r_cov[COUNT_W-1:0];

        if (i_start) begin
            // A start mark always opens a new frame, dropping any partial one.
            n_is_long = (i_byte == LONG_MARK);
            n_len     = 16'd0;
            n_cnt     = 16'd0;
            n_crc     = CRC_INIT;
            n_phase   = PH_START2;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_START2: begin
                    n_phase = r_is_long ? PH_LEN_HI : PH_LEN_LO;
                end
                PH_LEN_HI: begin
                    n_len   = {i_byte, 8'h00};
                    n_crc   = w_fold;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {r_len[15:8], i_byte};
                    n_crc   = w_fold;
                    n_phase = PH_PROTO;
                end
                PH_PROTO: begin
                    n_crc    = w_fold;
                    n_ptotal = w_ptotal;
                    n_cov    = w_cov;
                    if (r_is_long) begin
                        n_phase = PH_INFO;
                    end else begin
                        n_cnt   = 16'd0;
                        n_phase = (w_ptotal == 16'd0) ? PH_SER1 : PH_PAYLOAD;
                    end
                end
                PH_INFO: begin
                    n_crc   = w_fold;
                    n_cnt   = 16'd0;
                    n_phase = (r_ptotal == 16'd0) ? PH_SER1 : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    // Bytes past the covered count are consumed but not folded.
                    if (r_cnt < r_cov) begin
                        n_crc = w_fold;
                    end
                    n_cnt = r_cnt + 16'd1;
                    if (({1'b0, r_cnt} + 17'd1) >= {1'b0, r_ptotal}) begin
                        n_phase = PH_SER1;
                    end
                end
                PH_SER1: begin
                    n_crc   = w_fold;
                    n_phase = PH_SER2;
                end
                PH_SER2: begin
                    n_crc          = w_fold;
                    o_result.valid = 1'b1;
                    n_phase        = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // State registers, updated once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_is_long <= 1'b0;
            r_len     <= 16'd0;
            r_cnt     <= 16'd0;
            r_crc     <= CRC_INIT;
            r_ptotal  <= 16'd0;
            r_cov     <= 16'd0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_is_long <= n_is_long;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_crc     <= n_crc;
            r_ptotal  <= n_ptotal;
            r_cov     <= n_cov;
        end
    end

endmodule
